@@ rtl/olal_pkg.sv @@
`timescale 1ns / 1ps

package olal_pkg;

  // Widths of the beat fields.
  localparam int unsigned OP_W = 2;
  localparam int unsigned POS_W = 6;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned STATUS_W = 4;

  // Default number of list entries.
  localparam int unsigned DEPTH_DEF = 32;

  // Operation codes on the input channel. Code three is ignored.
  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 2'd0,
    OP_DELETE   = 2'd1,
    OP_TRAVERSE = 2'd2
  } opcode_t;

  // Status codes on the result channel.
  typedef enum logic [STATUS_W-1:0] {
    ST_FIRST   = 4'd0,
    ST_END     = 4'd1,
    ST_MIDDLE  = 4'd2,
    ST_BADPOS  = 4'd3,
    ST_DELETED = 4'd4,
    ST_NONE    = 4'd5,
    ST_ELEMENT = 4'd6,
    ST_EMPTY   = 4'd7,
    ST_FULL    = 4'd8
  } status_t;

  // Action that every cell of the chain takes on the current command.
  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_INSERT,
    ACT_SHIFT_DOWN,
    ACT_ROTATE
  } cell_act_t;

  // Command broadcast along the chain.
  typedef struct packed {
    cell_act_t                action;
    logic signed [VAL_W-1:0]  value;
  } chain_cmd_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_DELETE,
    S_TRAVERSE
  } state_t;

endpackage

@@ rtl/olal_in_if.sv @@
`timescale 1ns / 1ps

interface olal_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [olal_pkg::OP_W-1:0]            opcode;
  logic [olal_pkg::POS_W-1:0]           position;
  logic signed [olal_pkg::VAL_W-1:0]    item_value;

  modport source (output valid, output opcode, output position, output item_value,
                  input ready);
  modport sink (input valid, input opcode, input position, input item_value,
                output ready);
endinterface

@@ rtl/olal_out_if.sv @@
`timescale 1ns / 1ps

interface olal_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [olal_pkg::STATUS_W-1:0]        status;
  logic signed [olal_pkg::VAL_W-1:0]    element;
  logic                                 last;

  modport source (output valid, output status, output element, output last,
                  input ready);
  modport sink (input valid, input status, input element, input last,
                output ready);
endinterface

@@ rtl/ordered_array_list_core.sv @@
`timescale 1ns / 1ps

// Ordered list of signed 32-bit values held in a row of DEPTH cells, one entry
// per cell, with an entry count. Every input beat gives one result beat,
// except a traverse of a non-empty list, which gives one beat per entry with
// last set on the final one, and opcode three, which gives none. An insert
// finishes in the cycle it is taken: the cell at the position takes the new
// value and those above it load from their lower neighbor in one step. A
// delete scans the list, one cell per cycle while no match is found, closing
// the gap on a match, and gives its result when the scan reaches the count.
// A traverse rotates the list through the head cell and puts out one entry
// per cycle when the result side keeps up. One item is worked on at a time.
// A new item is taken only when the output register is empty or its beat
// leaves in the same cycle, so a stalled result holds off the input.
module ordered_array_list_core #(
  parameter int unsigned DEPTH = olal_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  olal_in_if.sink           in_beat,
  olal_out_if.source        out_beat
);
  import olal_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  state_t state_r;
  state_t state_nxt;

  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic [CW-1:0] k_r;
  logic [CW-1:0] k_nxt;
  logic [CW-1:0] orig_r;
  logic [CW-1:0] orig_nxt;
  logic signed [VAL_W-1:0] val_r;

  logic                    out_valid_r;
  status_t                 out_status_r;
  logic signed [VAL_W-1:0] out_element_r;
  logic                    out_last_r;

  logic can_emit;
  logic acc;
  logic emit;
  status_t                 res_status;
  logic signed [VAL_W-1:0] res_element;
  logic                    res_last;

  chain_cmd_t              cmd;
  logic [CW-1:0]           chain_idx;
  logic signed [VAL_W-1:0] head;
  logic                    match_at;

  logic [EW-1:0] pos_e;
  logic [EW-1:0] cnt_e;
  logic          bad_pos;
  logic          trav_last;

  assign can_emit = !out_valid_r || out_beat.ready;
  assign in_beat.ready = (state_r == S_IDLE) && can_emit;
  assign acc = in_beat.valid && in_beat.ready;

  assign pos_e = EW'(in_beat.position);
  assign cnt_e = EW'(cnt_r);
  assign bad_pos = (pos_e == '0) || (pos_e > cnt_e + EW'(1));
  assign trav_last = ((k_r + CW'(1)) == cnt_r);

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc && cnt_r != '0) begin
          if (opcode_t'(in_beat.opcode) == OP_DELETE) begin
            state_nxt = S_DELETE;
          end else if (opcode_t'(in_beat.opcode) == OP_TRAVERSE) begin
            state_nxt = S_TRAVERSE;
          end
        end
      end
      S_DELETE: begin
        if (k_r == cnt_r && can_emit) begin
          state_nxt = S_IDLE;
        end
      end
      S_TRAVERSE: begin
        if (can_emit && trav_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Chain command, counters and the result to emit.
  always_comb begin
    cmd.action  = ACT_HOLD;
    cmd.value   = val_r;
    chain_idx   = k_r;
    cnt_nxt     = cnt_r;
    k_nxt       = k_r;
    orig_nxt    = orig_r;
    emit        = 1'b0;
    res_status  = ST_NONE;
    res_element = '0;
    res_last    = 1'b1;
    case (state_r)
      S_IDLE: begin
        cmd.value = in_beat.item_value;
        if (acc) begin
          k_nxt    = '0;
          orig_nxt = cnt_r;
          case (opcode_t'(in_beat.opcode))
            OP_INSERT: begin
              emit = 1'b1;
              if (cnt_r == '0) begin
                cmd.action = ACT_INSERT;
                chain_idx  = '0;
                cnt_nxt    = CW'(1);
                res_status = ST_FIRST;
              end else if (bad_pos) begin
                res_status = ST_BADPOS;
              end else if (cnt_r == FULL_CNT) begin
                res_status = ST_FULL;
              end else begin
                cmd.action = ACT_INSERT;
                chain_idx  = CW'(pos_e - EW'(1));
                cnt_nxt    = cnt_r + CW'(1);
                res_status = (pos_e == cnt_e + EW'(1)) ? ST_END : ST_MIDDLE;
              end
            end
            OP_DELETE: begin
              if (cnt_r == '0) begin
                emit       = 1'b1;
                res_status = ST_NONE;
              end
            end
            OP_TRAVERSE: begin
              if (cnt_r == '0) begin
                emit       = 1'b1;
                res_status = ST_EMPTY;
              end
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
      end
      S_DELETE: begin
        if (k_r == cnt_r) begin
          emit       = can_emit;
          res_status = (cnt_r != orig_r) ? ST_DELETED : ST_NONE;
        end else if (match_at) begin
          cmd.action = ACT_SHIFT_DOWN;
          cnt_nxt    = cnt_r - CW'(1);
        end else begin
          k_nxt = k_r + CW'(1);
        end
      end
      S_TRAVERSE: begin
        res_status  = ST_ELEMENT;
        res_element = head;
        res_last    = trav_last;
        if (can_emit) begin
          emit       = 1'b1;
          cmd.action = ACT_ROTATE;
          k_nxt      = k_r + CW'(1);
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      k_r         <= '0;
      orig_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
      orig_r  <= orig_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_beat.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (acc) begin
      val_r <= in_beat.item_value;
    end
    if (emit) begin
      out_status_r  <= res_status;
      out_element_r <= res_element;
      out_last_r    <= res_last;
    end
  end

  olal_chain #(
    .DEPTH (DEPTH)
  ) u_chain (
    .clk      (clk),
    .cmd      (cmd),
    .idx      (chain_idx),
    .cnt      (cnt_r),
    .head     (head),
    .match_at (match_at)
  );

  assign out_beat.valid   = out_valid_r;
  assign out_beat.status  = out_status_r;
  assign out_beat.element = out_element_r;
  assign out_beat.last    = out_last_r;

endmodule

@@ rtl/olal_cell.sv @@
`timescale 1ns / 1ps

module olal_cell #(
  parameter int unsigned DEPTH = olal_pkg::DEPTH_DEF,
  parameter int unsigned INDEX = 0,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic                               clk,
  input  olal_pkg::chain_cmd_t               cmd,
  input  logic [CW-1:0]                      idx,
  input  logic [CW-1:0]                      cnt,
  input  logic signed [olal_pkg::VAL_W-1:0]  left_data,
  input  logic signed [olal_pkg::VAL_W-1:0]  right_data,
  input  logic signed [olal_pkg::VAL_W-1:0]  head_data,
  output logic signed [olal_pkg::VAL_W-1:0]  data,
  output logic                               match
);
  import olal_pkg::*;

  localparam logic [CW-1:0] MY_IDX = CW'(INDEX);
  localparam logic [CW-1:0] NEXT_IDX = CW'(INDEX + 1);

  logic signed [VAL_W-1:0] data_r;
  logic signed [VAL_W-1:0] data_nxt;

  // Pick the new entry from this cell, a neighbor, the head or the new value.
  always_comb begin
    data_nxt = data_r;
    case (cmd.action)
      ACT_INSERT: begin
        if (MY_IDX == idx) begin
          data_nxt = cmd.value;
        end else if (MY_IDX > idx) begin
          data_nxt = left_data;
        end
      end
      ACT_SHIFT_DOWN: begin
        if (MY_IDX >= idx) begin
          data_nxt = right_data;
        end
      end
      ACT_ROTATE: begin
        if (NEXT_IDX < cnt) begin
          data_nxt = right_data;
        end else if (NEXT_IDX == cnt) begin
          data_nxt = head_data;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  assign match = (data_r == cmd.value);

endmodule

@@ rtl/olal_chain.sv @@
`timescale 1ns / 1ps

module olal_chain #(
  parameter int unsigned DEPTH = olal_pkg::DEPTH_DEF,
  localparam int unsigned CW = $clog2(DEPTH + 1),
  localparam int unsigned IW = $clog2(DEPTH)
) (
  input  logic                               clk,
  input  olal_pkg::chain_cmd_t               cmd,
  input  logic [CW-1:0]                      idx,
  input  logic [CW-1:0]                      cnt,
  output logic signed [olal_pkg::VAL_W-1:0]  head,
  output logic                               match_at
);
  import olal_pkg::*;

  logic signed [VAL_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]        cell_match;

  // Row of cells; each sees its neighbors (an end cell sees itself in place of the missing one) and the head.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [VAL_W-1:0] left_d;
    logic signed [VAL_W-1:0] right_d;

    if (g == 0) begin : g_first
      assign left_d = cell_data[g];
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_final
      assign right_d = cell_data[g];
    end else begin : g_mid_r
      assign right_d = cell_data[g+1];
    end

    olal_cell #(
      .DEPTH (DEPTH),
      .INDEX (g)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .idx        (idx),
      .cnt        (cnt),
      .left_data  (left_d),
      .right_data (right_d),
      .head_data  (cell_data[0]),
      .data       (cell_data[g]),
      .match      (cell_match[g])
    );
  end

  assign head = cell_data[0];

  // Compare result of the cell under the scan pointer.
  assign match_at = cell_match[idx[IW-1:0]];

endmodule

@@ rtl/olal_checker.sv @@
`timescale 1ns / 1ps

module olal_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [olal_pkg::STATUS_W-1:0]       out_status,
  input logic signed [olal_pkg::VAL_W-1:0]   out_element,
  input logic                                out_last
);
  import olal_pkg::*;

  // A stalled result beat holds its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_element) && $stable(out_last))
    else $error("result beat changed while stalled");

  // Only element beats can be followed by more beats of the same item.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_ELEMENT |-> out_last)
    else $error("non-element result without last");

  // The element field is zero on every non-element result.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_ELEMENT |-> out_element == '0)
    else $error("element field set on a non-element result");

  // No new item is taken while a traverse still has entries to give.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken in the middle of a traverse");

  // An input beat that is not taken stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input beat withdrawn before it was taken");

endmodule

bind ordered_array_list_core olal_checker u_olal_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_beat.valid),
  .in_ready    (in_beat.ready),
  .out_valid   (out_beat.valid),
  .out_ready   (out_beat.ready),
  .out_status  (out_beat.status),
  .out_element (out_beat.element),
  .out_last    (out_beat.last)
);
